// ===== hdl/sorted_id_set_with_free_pick_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted ID set - assertion macros
// Shared concurrent assertion forms; they expect i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_ID_SET_WITH_FREE_PICK_DEFINES_SVH
`define SORTED_ID_SET_WITH_FREE_PICK_DEFINES_SVH

// same-cycle implication
`define SIDF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIDF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sidf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted ID set - package
// Field widths, operation codes, cell link types and controller states.
// ----------------------------------------------------------------------------
package sidf_pkg;

    localparam int VAL_W      = 32;
    localparam int MODE_W     = 2;
    localparam int RES_W      = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // operation codes (tuser of the input stream)
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    // what one cell shows its neighbors
    typedef struct packed {
        logic             occ;
        logic             lt;
        logic [VAL_W-1:0] val;
    } t_link;

    // broadcast control to every cell
    typedef struct packed {
        logic cmp;
        logic add;
        logic rem;
    } t_cell_ctrl;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_UPD  = 5'b00100,
        S_CALC = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

endpackage

// ===== hdl/sidf_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted ID set - storage cell
// Holds one sorted entry, compares it with the broadcast value and shifts
// left or right with its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module sidf_cell
    import sidf_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_zero,    // cell 0 holds the value 0
    input  t_link            i_left,
    input  t_link            i_right,
    output t_link            o_link,
    output logic             o_eq,
    output logic             o_tight
);

    logic             r_occ, n_occ;
    logic             r_lt, n_lt;
    logic             r_eq, n_eq;
    logic [VAL_W-1:0] r_val, n_val;

    // compare, then insert/remove shifting
    always_comb begin
        n_lt  = r_lt;
        n_eq  = r_eq;
        n_val = r_val;
        n_occ = r_occ;
        if (i_ctrl.cmp) begin
            n_lt = r_occ && (r_val < i_value);
            n_eq = r_occ && (r_val == i_value);
        end
        if (i_ctrl.add && !r_lt) begin
            if (i_left.lt) begin
                n_val = i_value;
                n_occ = 1'b1;
            end else begin
                n_val = i_left.val;
                n_occ = i_left.occ;
            end
        end
        if (i_ctrl.rem && !r_lt) begin
            n_val = i_right.val;
            n_occ = i_right.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_lt  <= n_lt;
            r_eq  <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    // entry sits on the run 1,2,3,... (shifted by one when a zero is held)
    always_comb begin
        if (i_zero) begin
            o_tight = r_occ && (IDX != 0) && (r_val == VAL_W'(IDX));
        end else begin
            o_tight = r_occ && (r_val == VAL_W'(IDX + 1));
        end
    end

    assign o_link = '{occ: r_occ, lt: r_lt, val: r_val};
    assign o_eq   = r_eq;

endmodule

// ===== hdl/sidf_cnt_tree.sv =====
// ----------------------------------------------------------------------------
// Sorted ID set - count tree
// Registered binary adder tree counting set flags; one level per cycle.
// ----------------------------------------------------------------------------
module sidf_cnt_tree #(
    parameter int N  = 64,
    parameter int SW = 7
) (
    input  logic          i_clk,
    input  logic [N-1:0]  i_leaf,
    output logic [SW-1:0] o_sum
);

    localparam int NP = 2 ** $clog2(N);

    logic [NP-1:0] w_leaf;
    logic [SW-1:0] r_sum [NP-1];

    assign w_leaf = NP'(i_leaf);

    // heap order: node i has children 2i+1 and 2i+2, leaves start at NP-1
    for (genvar i = 0; i < NP - 1; i++) begin : g_node
        if (2 * i + 1 >= NP - 1) begin : g_bottom
            always_ff @(posedge i_clk) begin
                r_sum[i] <= SW'(w_leaf[2 * i + 1 - (NP - 1)])
                          + SW'(w_leaf[2 * i + 2 - (NP - 1)]);
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_sum[i] <= r_sum[2 * i + 1] + r_sum[2 * i + 2];
            end
        end
    end

    assign o_sum = r_sum[0];

endmodule

// ===== hdl/sorted_id_set_with_free_pick.sv =====
// ----------------------------------------------------------------------------
// Sorted ID set with lowest free ID
// Ascending set of unique 32-bit values in a chain of cells; add, remove or
// find one value per transaction, reporting the count and lowest free ID.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                        tuser
//  s_axis    in   [31:0] value                 [1:0] mode
//  m_axis    out  [0] success [1] full_res     -
//                 [8:2] entry_count [15:9] lowest_free
//
//  One transaction at a time: no new accept until the result of the last is
//  loaded; the wait is set by the depth of the registered count tree.
//  Steps: latch, compare in all cells, shift, count tree, load output.
//  A result waiting on m_axis holds the block after the count tree finishes.
//  Synchronous active-low reset empties the set; no clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_id_set_with_free_pick_defines.svh"

module sorted_id_set_with_free_pick
    import sidf_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [MODE_W-1:0]     s_axis_tuser,   // [1:0] mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // success, full_res,
                                                  // entry_count, lowest_free
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LG  = $clog2(CAPACITY);
    localparam int TW  = $clog2(LG + 1);
    localparam int TSW = $clog2((2 ** LG) + 1);

    t_state r_state, n_state;

    logic [MODE_W-1:0] r_mode;
    logic [VAL_W-1:0]  r_value;
    logic [CW-1:0]     r_count, n_count;
    logic [TW-1:0]     r_tmr;
    logic              r_succ, n_succ;
    logic              r_full, n_full;
    logic              r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    t_cell_ctrl        w_ctrl;
    t_link             w_link  [CAPACITY];
    t_link             w_left  [CAPACITY];
    t_link             w_right [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_tight;
    logic [CAPACITY-1:0] w_occ_vec;
    logic              w_zero;
    logic              w_present;
    logic              w_is_full;
    logic              w_accept;
    logic              w_out_free;
    logic              w_load;
    logic [TSW-1:0]    w_root;
    logic [TSW+RES_W-1:0] w_lf_ext;
    logic [CW+RES_W-1:0]  w_cnt_ext;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_present  = |w_eq;
    assign w_is_full  = (r_count == CW'(CAPACITY));
    assign w_zero     = w_link[0].occ && (w_link[0].val == '0);

    // cell control
    assign w_ctrl.cmp = (r_state == S_CMP);
    assign w_ctrl.add = (r_state == S_UPD) && (r_mode == MODE_ADD) &&
                        !w_present && !w_is_full;
    assign w_ctrl.rem = (r_state == S_UPD) && (r_mode == MODE_REMOVE) && w_present;

    // cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_left[k] = '{occ: 1'b0, lt: 1'b1, val: '0};
        end else begin : g_mid_l
            assign w_left[k] = w_link[k-1];
        end
        if (k == CAPACITY - 1) begin : g_tail
            assign w_right[k] = '{occ: 1'b0, lt: 1'b0, val: '0};
        end else begin : g_mid_r
            assign w_right[k] = w_link[k+1];
        end

        sidf_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_value (r_value),
            .i_zero  (w_zero),
            .i_left  (w_left[k]),
            .i_right (w_right[k]),
            .o_link  (w_link[k]),
            .o_eq    (w_eq[k]),
            .o_tight (w_tight[k])
        );

        assign w_occ_vec[k] = w_link[k].occ;
    end

    // count of entries on the run 1,2,3,... gives lowest free minus one
    sidf_cnt_tree #(
        .N  (CAPACITY),
        .SW (TSW)
    ) u_cnt_tree (
        .i_clk  (i_clk),
        .i_leaf (w_tight),
        .o_sum  (w_root)
    );

    assign w_lf_ext  = (TSW + RES_W)'(w_root) + (TSW + RES_W)'(1);
    assign w_cnt_ext = (CW + RES_W)'(r_count);
    assign w_load    = ((r_state == S_CALC && r_tmr == '0) || r_state == S_HOLD) &&
                       w_out_free;

    // result flags and count update
    always_comb begin
        n_succ  = r_succ;
        n_full  = r_full;
        n_count = r_count;
        if (r_state == S_UPD) begin
            n_succ = 1'b0;
            n_full = 1'b0;
            case (r_mode)
                MODE_ADD: begin
                    n_succ = !w_present && !w_is_full;
                    n_full = !w_present && w_is_full;
                end
                MODE_REMOVE: n_succ = w_present;
                MODE_FIND:   n_succ = w_present;
                default:     n_succ = 1'b0;
            endcase
            if (w_ctrl.add) begin
                n_count = r_count + CW'(1);
            end else if (w_ctrl.rem) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD:  n_state = S_CALC;
            S_CALC: begin
                if (r_tmr == '0) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_tmr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_UPD) begin
                r_tmr <= TW'(LG);
            end else if (r_state == S_CALC && r_tmr != '0) begin
                r_tmr <= r_tmr - TW'(1);
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_succ <= n_succ;
        r_full <= n_full;
        if (w_accept) begin
            r_mode  <= s_axis_tuser;
            r_value <= s_axis_tdata;
        end
        if (w_load) begin
            r_odata <= {w_lf_ext[RES_W-1:0], w_cnt_ext[RES_W-1:0], r_full, r_succ};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // checks
    `SIDF_ASSERT_IMP(a_occ_count, 1'b1, $countones(w_occ_vec) == int'(r_count),
        "occupied cells disagree with entry count")
    `SIDF_ASSERT_IMP(a_occ_prefix, 1'b1, ((w_occ_vec + 1'b1) & w_occ_vec) == '0,
        "occupied cells not contiguous from cell 0")
    `SIDF_ASSERT_NXT(a_add_count, w_ctrl.add, r_count == $past(r_count) + CW'(1),
        "insert did not raise entry count")
    `SIDF_ASSERT_IMP(a_full_excl, r_ovalid, !(r_odata[0] && r_odata[1]),
        "success and full both set")

    for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_chk
        `SIDF_ASSERT_IMP(a_sorted, w_link[k].occ && w_link[k+1].occ,
            w_link[k].val < w_link[k+1].val, "cell chain out of order")
    end

endmodule

// ===== verif/tb_sorted_id_set_with_free_pick.sv =====
// ----------------------------------------------------------------------------
// Testbench - sorted ID set with lowest free ID
// Drives add, remove, find and spare-mode transactions into the set, tracks
// the set contents in a local sorted array, and checks every result field
// (success, full flag, entry count, lowest free ID) in order. Runs corner
// values, a fill-to-capacity sequence and random traffic under several
// sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_sorted_id_set_with_free_pick
    import sidf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAPACITY      = 64;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 24;

    // mode 3 is not defined by the block: no operation
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic             success;
        logic             full_res;
        logic [RES_W-1:0] entry_count;
        logic [RES_W-1:0] lowest_free;
    } t_set_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] value
    logic [MODE_W-1:0]     s_axis_tuser  = '0;   // [1:0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [0] success, [1] full_res,
                                                 // [8:2] entry_count,
                                                 // [15:9] lowest_free

    // local copy of the set, ascending
    logic [VAL_W-1:0] held_vals [CAPACITY];
    int unsigned      held_num = 0;

    t_set_result expected_results [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    sorted_id_set_with_free_pick #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, 4 ns
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // apply one operation to the local set, return the expected result
    function automatic t_set_result apply_set_op(input logic [MODE_W-1:0] mode,
                                                 input logic [VAL_W-1:0]  value);
        int unsigned pos;
        int unsigned k;
        int unsigned cand;
        bit          present;
        t_set_result res;
        pos = 0;
        while (pos < held_num && held_vals[pos] < value)
            pos++;
        present = (pos < held_num) && (held_vals[pos] == value);
        res = '0;
        case (mode)
            MODE_ADD: begin
                // duplicate check wins over the full check
                if (!present) begin
                    if (held_num >= CAPACITY) begin
                        res.full_res = 1'b1;
                    end else begin
                        for (k = held_num; k > pos; k--)
                            held_vals[k] = held_vals[k-1];
                        held_vals[pos] = value;
                        held_num++;
                        res.success = 1'b1;
                    end
                end
            end
            MODE_REMOVE: begin
                if (present) begin
                    for (k = pos; k + 1 < held_num; k++)
                        held_vals[k] = held_vals[k+1];
                    held_num--;
                    res.success = 1'b1;
                end
            end
            MODE_FIND: res.success = present;
            default: ;
        endcase
        res.entry_count = held_num[RES_W-1:0];
        // lowest free: skip held values below the candidate (a held 0 too)
        cand = 1;
        for (k = 0; k < held_num; k++) begin
            if (held_vals[k] == cand)
                cand++;
            else if (held_vals[k] > cand)
                break;
        end
        res.lowest_free = cand[RES_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // one input transaction; entered and left at a falling edge
    task automatic issue_op(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(apply_set_op(mode, value));
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checking
    always @(posedge i_clk) begin : result_check
        t_set_result got_res;
        t_set_result want_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.success     = m_axis_tdata[0];
            got_res.full_res    = m_axis_tdata[1];
            got_res.entry_count = m_axis_tdata[8:2];
            got_res.lowest_free = m_axis_tdata[15:9];
            if (expected_results.size() == 0) begin
                flag_mismatch("unexpected result, tdata", m_axis_tdata, 0);
            end else begin
                want_res = expected_results.pop_front();
                if (got_res.success !== want_res.success)
                    flag_mismatch("success", got_res.success, want_res.success);
                if (got_res.full_res !== want_res.full_res)
                    flag_mismatch("full_res", got_res.full_res, want_res.full_res);
                if (got_res.entry_count !== want_res.entry_count)
                    flag_mismatch("entry_count", got_res.entry_count,
                                  want_res.entry_count);
                if (got_res.lowest_free !== want_res.lowest_free)
                    flag_mismatch("lowest_free", got_res.lowest_free,
                                  want_res.lowest_free);
            end
        end
    end

    // value source: mostly small IDs so they collide, some wide ones
    function automatic logic [VAL_W-1:0] pick_value(input int unsigned held_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (held_num > 0 && $urandom_range(99) < held_pct)
            return held_vals[$urandom_range(held_num - 1)];
        if (roll < 70)
            return $urandom_range(72);
        if (roll < 88)
            return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(3);
    endfunction

    // extremes, every mode, duplicates, absent values, held zero
    task automatic test_corner_values();
        issue_op(MODE_FIND,   32'd0);
        issue_op(MODE_REMOVE, 32'd5);
        issue_op(MODE_ADD,    32'd0);           // held zero, lowest free stays 1
        issue_op(MODE_ADD,    32'd0);           // duplicate
        issue_op(MODE_ADD,    32'hFFFF_FFFF);
        issue_op(MODE_ADD,    32'd1);
        issue_op(MODE_ADD,    32'd3);
        issue_op(MODE_ADD,    32'd2);           // fills the gap, lowest free 4
        issue_op(MODE_FIND,   32'd2);
        issue_op(MODE_FIND,   32'hFFFF_FFFE);
        issue_op(MODE_SPARE,  32'd2);
        issue_op(MODE_SPARE,  32'hFFFF_FFFF);
        issue_op(MODE_REMOVE, 32'd2);
        issue_op(MODE_REMOVE, 32'd2);           // now absent
        issue_op(MODE_ADD,    32'h8000_0000);
        issue_op(MODE_FIND,   32'h8000_0000);
        issue_op(MODE_REMOVE, 32'hFFFF_FFFF);
        issue_op(MODE_REMOVE, 32'd0);
        issue_op(MODE_ADD,    32'h5555_5555);
        issue_op(MODE_ADD,    32'hAAAA_AAAA);
        issue_op(MODE_FIND,   32'hAAAA_AAAA);
    endtask

    // fill the store, then refused adds, duplicate on full and holes
    task automatic test_full_store();
        int unsigned k;
        while (held_num > 0)
            issue_op(MODE_REMOVE, held_vals[$urandom_range(held_num - 1)]);
        // descending, so each add inserts at the front
        for (k = CAPACITY; k >= 1; k--)
            issue_op(MODE_ADD, k);
        issue_op(MODE_ADD,    32'd100);         // full
        issue_op(MODE_ADD,    32'd5);           // duplicate on full: no flag
        issue_op(MODE_FIND,   CAPACITY);
        issue_op(MODE_ADD,    32'd0);           // full
        issue_op(MODE_REMOVE, 32'd17);
        issue_op(MODE_ADD,    32'd0);           // held zero skipped, lowest 17
        issue_op(MODE_ADD,    32'd17);          // full
        issue_op(MODE_ADD,    32'hFFFF_FFFF);   // full
        issue_op(MODE_REMOVE, 32'd0);
        issue_op(MODE_FIND,   32'd0);
        issue_op(MODE_REMOVE, CAPACITY);
        issue_op(MODE_REMOVE, 32'd1);           // lowest free back to 1
    endtask

    // random traffic in grow and shrink bursts so the store fills and drains
    task automatic test_mixed_traffic(input int unsigned n_items,
                                      input int unsigned idle_pct,
                                      input int unsigned stall_pct);
        int unsigned      n;
        int unsigned      roll;
        int unsigned      burst_left;
        bit               growing;
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  value;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        growing    = (held_num < CAPACITY / 2);
        burst_left = $urandom_range(60, 120);
        for (n = 0; n < n_items; n++) begin
            if (burst_left == 0) begin
                growing    = !growing;
                burst_left = $urandom_range(60, 120);
            end
            burst_left--;
            roll = $urandom_range(99);
            if (roll < (growing ? 55 : 20))
                mode = MODE_ADD;
            else if (roll < 75)
                mode = MODE_REMOVE;
            else if (roll < 95)
                mode = MODE_FIND;
            else
                mode = MODE_SPARE;
            value = pick_value((mode == MODE_ADD) ? 20 : 65);
            issue_op(mode, value);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_corner_values();
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        test_full_store();
        test_mixed_traffic(250, 0, 0);
        test_mixed_traffic(250, 69, 0);
        test_mixed_traffic(250, 0, 69);
        test_mixed_traffic(250, 22, 22);
        s_axis_tvalid <= 1'b0;

        // drain, then allow stray results to show up
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
